[rtl/tcw_pkg.sv]
// Package for the text console writer.
// Holds the transaction structs, op codes and character constants.
// No dependencies.
package tcw_pkg;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic [4:0] cell_row;
		logic [6:0] cell_col;
	} cmd_t;

	typedef struct packed {
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic [7:0] cell_char;
		logic       scrolled;
	} rsp_t;

endpackage

[rtl/tcw_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/text_console_writer.sv]
// Text console writer top level: cursor control, screen sweeps and result register.
// Depends on tcw_pkg and tcw_ram.
//
// A ROWS x COLS text screen kept in one single-port-write RAM, with a cursor held as
// row, column and linear cell address. One command is worked at a time, and the
// command port stalls until it is finished. A plain character or newline passes
// through EXEC and PUT to DONE, a cell read through EXEC, READ and RWAIT, a clear
// through EXEC, SWEEP and FLUSH, and a put that first scrolls through EXEC, SWEEP,
// FLUSH and PUT; DONE loads the result register once it is free. The sweep moves
// or blanks one cell per cycle through the RAM's single write port. After reset the
// same sweep blanks the screen before the first command is accepted.
module text_console_writer #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tcw_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tcw_pkg::rsp_t rsp
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = ROWS * COLS;
	localparam int MOVE_CNT   = CELL_COUNT - COLS;
	localparam int RAM_AW     = $clog2(CELL_COUNT);
	localparam int ADDR_W     = $clog2(CELL_COUNT + 1);
	localparam int ROW_W      = $clog2(ROWS + 1);
	localparam int COL_W      = $clog2(COLS);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EXEC  = 8'b0000_0010,
		ST_SWEEP = 8'b0000_0100,
		ST_FLUSH = 8'b0000_1000,
		ST_PUT   = 8'b0001_0000,
		ST_READ  = 8'b0010_0000,
		ST_RWAIT = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [RAM_AW-1:0]  idx_q;
	logic               copy_q;
	logic               init_q;
	logic               scrolled_q;
	logic [7:0]         char_res_q;
	logic               in_range_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               wr_en_s1;
	logic               wr_copy_s1;
	logic [RAM_AW-1:0]  wr_dst_s1;

	logic               ram_we;
	logic [RAM_AW-1:0]  ram_waddr;
	logic [7:0]         ram_wdata;
	logic [RAM_AW-1:0]  ram_raddr;
	logic [7:0]         ram_rdata;
	logic               idx_copy;
	logic               rd_in_range;
	logic [RAM_AW-1:0]  rd_cell_addr;
	logic               rsp_free;

	tcw_ram #(
		.WIDTH (8),
		.DEPTH (CELL_COUNT),
		.AW    (RAM_AW)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign idx_copy     = copy_q && (32'(idx_q) < 32'(MOVE_CNT));
	assign rd_in_range  = (32'(cmd_q.cell_row) < 32'(ROWS)) && (32'(cmd_q.cell_col) < 32'(COLS));
	assign rd_cell_addr = RAM_AW'(32'(cmd_q.cell_row) * 32'(COLS) + 32'(cmd_q.cell_col));
	assign rsp_free     = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q[RAM_AW-1:0];
		ram_wdata = cmd_q.char_code;
		ram_raddr = idx_q;
		if (wr_en_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_dst_s1;
			ram_wdata = wr_copy_s1 ? ram_rdata : BLANK_CODE;
		end else if (state_q == ST_PUT && cmd_q.char_code != NEWLINE_CODE) begin
			ram_we = 1'b1;
		end
		if (state_q == ST_READ) begin
			ram_raddr = rd_cell_addr;
		end else if (idx_copy) begin
			ram_raddr = RAM_AW'(32'(idx_q) + 32'(COLS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			cmd_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			addr_q      <= '0;
			idx_q       <= '0;
			copy_q      <= 1'b0;
			init_q      <= 1'b1;
			scrolled_q  <= 1'b0;
			char_res_q  <= '0;
			in_range_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			wr_en_s1    <= 1'b0;
			wr_copy_s1  <= 1'b0;
			wr_dst_s1   <= '0;
		end else begin
			wr_en_s1   <= (state_q == ST_SWEEP);
			wr_copy_s1 <= idx_copy;
			wr_dst_s1  <= idx_q;

			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q      <= cmd;
						scrolled_q <= 1'b0;
						char_res_q <= '0;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q.op)
						OP_PUT: begin
							if (32'(row_q) == 32'(ROWS)) begin
								row_q      <= row_q - ROW_W'(1);
								addr_q     <= addr_q - ADDR_W'(COLS);
								scrolled_q <= 1'b1;
								copy_q     <= 1'b1;
								idx_q      <= '0;
								state_q    <= ST_SWEEP;
							end else begin
								state_q <= ST_PUT;
							end
						end
						OP_CLEAR: begin
							row_q   <= '0;
							col_q   <= '0;
							addr_q  <= '0;
							copy_q  <= 1'b0;
							idx_q   <= '0;
							state_q <= ST_SWEEP;
						end
						OP_READ: begin
							state_q <= ST_READ;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_SWEEP: begin
					if (32'(idx_q) == CELL_COUNT - 1) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + RAM_AW'(1);
					end
				end
				ST_FLUSH: begin
					if (init_q) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (cmd_q.op == OP_PUT) begin
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_PUT: begin
					if (cmd_q.char_code == NEWLINE_CODE) begin
						row_q  <= row_q + ROW_W'(1);
						col_q  <= '0;
						addr_q <= addr_q - ADDR_W'(col_q) + ADDR_W'(COLS);
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
						if (32'(col_q) == COLS - 1) begin
							col_q <= '0;
							row_q <= row_q + ROW_W'(1);
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
					state_q <= ST_DONE;
				end
				ST_READ: begin
					in_range_q <= rd_in_range;
					state_q    <= ST_RWAIT;
				end
				ST_RWAIT: begin
					char_res_q <= in_range_q ? ram_rdata : 8'h00;
					state_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_q.cursor_row <= 5'(row_q);
						rsp_q.cursor_col <= 7'(col_q);
						rsp_q.cell_char  <= char_res_q;
						rsp_q.scrolled   <= scrolled_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) <= 32'(ROWS)) && ((32'(row_q) != 32'(ROWS)) || (col_q == '0)))
		else $error("cursor beyond scroll-pending position");

	a_addr_match: assert property (@(posedge clk) disable iff (!arst_n)
		32'(addr_q) == 32'(row_q) * 32'(COLS) + 32'(col_q))
		else $error("linear cursor address out of step with row and column");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && scrolled_q) |-> (32'(row_q) == ROWS - 1))
		else $error("put after scroll not on the last row");

	a_sweep_no_put: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |-> !wr_en_s1)
		else $error("character write collides with sweep write");

endmodule
